### hw/rtl/pcx_pkg.sv
// Shared types and constants for the permutation cycle crossover block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pcx_pkg;

    localparam int CITY_W = 6;
    localparam int CFG_W  = 7;
    localparam logic [CFG_W-1:0] CITY_COUNT_RST = 7'd64;

    // Sequencer steps; the controller state doubles as the datapath command.
    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_LOOP,
        S_F_RD,
        S_F_CK,
        S_G_RD,
        S_G_CK,
        S_C_INIT,
        S_CB_RD,
        S_CB_CK,
        S_CA_INIT,
        S_CA_RD,
        S_CA_CK,
        S_CK_RD,
        S_CK_CK,
        S_D_INIT,
        S_D_RD,
        S_D_CK,
        S_DK_RD,
        S_DK_CK,
        S_Y_RD,
        S_Y_CK,
        S_NEW_CYC,
        S_E_INIT,
        S_E_RD,
        S_E_CK
    } t_state;

    // Which lookup a search in list A serves.
    typedef enum logic [1:0] {
        CL_P1,
        CL_P2,
        CL_PE
    } t_caller;

    typedef struct packed {
        t_state  op;
        t_caller caller;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic load_last;
        logic loop_done;
        logic second;
        logic ca_zero;
        logic cb_zero;
        logic i_end;
        logic k_end_ca;
        logic k_end_rem;
        logic key_hit;
        logic cyc_hit;
        logic placed_hit;
        logic found_hit;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/pcx_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pcx_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pcx_ctrl.sv
// Sequencer for the crossover: loading, lookups, compaction and emission.
// Depends on pcx_pkg; drives the datapath through t_cmd, reads t_status.
`default_nettype none

module pcx_ctrl import pcx_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_stall
);

    t_state  r_state, n_state;
    t_caller r_caller, n_caller;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_caller <= CL_P1;
        end else begin
            r_state  <= n_state;
            r_caller <= n_caller;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_caller = r_caller;
        case (r_state)
            S_IDLE: begin
                if (i_status.in_fire && i_status.load_last) n_state = S_START;
            end
            S_START: n_state = S_LOOP;
            S_LOOP: begin
                if (i_status.loop_done) begin
                    n_state = S_E_INIT;
                end else if (i_status.second) begin
                    if (i_status.ca_zero) n_state = S_E_INIT;
                    else begin
                        n_caller = CL_P1;
                        n_state  = S_F_RD;
                    end
                end else begin
                    if (i_status.cb_zero) n_state = S_E_INIT;
                    else begin
                        n_caller = CL_PE;
                        n_state  = S_F_RD;
                    end
                end
            end
            S_F_RD: n_state = i_status.i_end ? S_E_INIT : S_F_CK;
            S_F_CK: n_state = i_status.key_hit ? S_G_RD : S_F_RD;
            S_G_RD: n_state = S_G_CK;
            S_G_CK: begin
                case (r_caller)
                    CL_P1: begin
                        n_caller = CL_P2;
                        n_state  = S_F_RD;
                    end
                    CL_P2: n_state = i_status.cyc_hit ? S_C_INIT : S_LOOP;
                    default: n_state = S_LOOP;
                endcase
            end
            S_C_INIT:  n_state = S_CB_RD;
            S_CB_RD:   n_state = i_status.i_end ? S_CA_INIT : S_CB_CK;
            S_CB_CK:   n_state = S_CB_RD;
            S_CA_INIT: n_state = S_CA_RD;
            S_CA_RD:   n_state = i_status.i_end ? S_D_INIT : S_CA_CK;
            S_CA_CK:   n_state = S_CK_RD;
            S_CK_RD:   n_state = i_status.k_end_ca ? S_CA_RD : S_CK_CK;
            S_CK_CK:   n_state = i_status.placed_hit ? S_CA_RD : S_CK_RD;
            S_D_INIT:  n_state = S_D_RD;
            S_D_RD:    n_state = i_status.i_end ? S_NEW_CYC : S_D_CK;
            S_D_CK:    n_state = S_DK_RD;
            S_DK_RD:   n_state = i_status.k_end_rem ? S_Y_RD : S_DK_CK;
            S_DK_CK:   n_state = i_status.found_hit ? S_D_RD : S_DK_RD;
            S_Y_RD:    n_state = i_status.k_end_rem ? S_E_INIT : S_Y_CK;
            S_Y_CK:    n_state = S_Y_RD;
            S_NEW_CYC: n_state = S_LOOP;
            S_E_INIT:  n_state = S_E_RD;
            S_E_RD:    n_state = S_E_CK;
            S_E_CK: begin
                if (i_status.out_free) n_state = i_status.emit_last ? S_IDLE : S_E_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op     = r_state;
    assign o_cmd.caller = r_caller;
    assign o_in_stall   = (r_state != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/pcx_dp.sv
// Datapath: working lists, child stores, taken marks, counters, output beat.
// Depends on pcx_pkg and pcx_ram; steered by t_cmd from pcx_ctrl.
`default_nettype none

module pcx_dp import pcx_pkg::*; #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_cmd                           i_cmd,
    output t_status                             o_status,
    input  wire logic [$clog2(MAX_CITIES+1)-1:0] i_city_n,
    input  wire logic                           i_in_valid,
    input  wire logic [CITY_W-1:0]              i_parent_a_city,
    input  wire logic [CITY_W-1:0]              i_parent_b_city,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [CITY_W-1:0]              o_child_a_city,
    output logic      [CITY_W-1:0]              o_child_b_city,
    output logic                                o_last,
    output logic                                o_lookup_error
);

    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int AW = $clog2(MAX_CITIES);
    localparam int GW = $clog2(4 * MAX_CITIES + 9);
    localparam logic [GW-1:0] GUARD_INIT = GW'(4 * MAX_CITIES + 8);

    logic [CW-1:0]         r_ld_pos, r_ca, r_cb, r_rem, r_cs, r_idx, r_i, r_k;
    logic [GW-1:0]         r_guard;
    logic                  r_second, r_err;
    logic [CITY_W-1:0]     r_last_a, r_last_b, r_a0, r_b0, r_key, r_v;
    logic [MAX_CITIES-1:0] r_marks;

    logic              wa_we, wa_re, wb_we, wb_re, ca_we, ca_re, cb_we, cb_re;
    logic [AW-1:0]     wa_waddr, wa_raddr, wb_waddr, wb_raddr;
    logic [AW-1:0]     ca_waddr, ca_raddr, cb_waddr, cb_raddr;
    logic [CITY_W-1:0] wa_wdata, wb_wdata, ca_wdata, cb_wdata;
    logic [CITY_W-1:0] wa_rd, wb_rd, ca_rd, cb_rd;

    logic              pa_en, pb_en, ca_room, cb_room;
    logic [CITY_W-1:0] pa_city, pb_city;
    logic              w_fire, w_i_end, w_k_end_rem, w_out_free, w_mark;

    pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_work_a (
        .i_clk(i_clk), .i_we(wa_we), .i_waddr(wa_waddr), .i_wdata(wa_wdata),
        .i_re(wa_re), .i_raddr(wa_raddr), .o_rdata(wa_rd)
    );
    pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_work_b (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(wb_waddr), .i_wdata(wb_wdata),
        .i_re(wb_re), .i_raddr(wb_raddr), .o_rdata(wb_rd)
    );
    pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_child_a (
        .i_clk(i_clk), .i_we(ca_we), .i_waddr(ca_waddr), .i_wdata(ca_wdata),
        .i_re(ca_re), .i_raddr(ca_raddr), .o_rdata(ca_rd)
    );
    pcx_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_child_b (
        .i_clk(i_clk), .i_we(cb_we), .i_waddr(cb_waddr), .i_wdata(cb_wdata),
        .i_re(cb_re), .i_raddr(cb_raddr), .o_rdata(cb_rd)
    );

    assign w_fire      = i_in_valid && (i_cmd.op == S_IDLE);
    assign w_i_end     = (r_i >= r_rem);
    assign w_k_end_rem = (r_k >= r_rem);
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign ca_room     = (r_ca < i_city_n);
    assign cb_room     = (r_cb < i_city_n);
    assign w_mark      = r_marks[r_i[AW-1:0]];

    assign o_status.in_fire    = w_fire;
    assign o_status.load_last  = ((r_ld_pos + CW'(1)) >= i_city_n);
    assign o_status.loop_done  = !(ca_room || cb_room) || (r_guard == '0);
    assign o_status.second     = r_second;
    assign o_status.ca_zero    = (r_ca == '0);
    assign o_status.cb_zero    = (r_cb == '0);
    assign o_status.i_end      = w_i_end;
    assign o_status.k_end_ca   = (r_k >= r_ca);
    assign o_status.k_end_rem  = w_k_end_rem;
    assign o_status.key_hit    = (wa_rd == r_key);
    assign o_status.cyc_hit    = (r_a0 == wb_rd);
    assign o_status.placed_hit = (ca_rd == r_v);
    assign o_status.found_hit  = (wb_rd == r_v);
    assign o_status.out_free   = w_out_free;
    assign o_status.emit_last  = ((r_k + CW'(1)) == i_city_n);

    always_comb begin
        wa_we = 1'b0; wa_waddr = r_idx[AW-1:0]; wa_wdata = r_v;
        wa_re = 1'b0; wa_raddr = r_i[AW-1:0];
        wb_we = 1'b0; wb_waddr = r_idx[AW-1:0]; wb_wdata = wb_rd;
        wb_re = 1'b0; wb_raddr = r_i[AW-1:0];
        ca_we = 1'b0; ca_waddr = r_ca[AW-1:0]; ca_wdata = r_b0;
        ca_re = 1'b0; ca_raddr = r_k[AW-1:0];
        cb_we = 1'b0; cb_waddr = r_cb[AW-1:0]; cb_wdata = wb_rd;
        cb_re = 1'b0; cb_raddr = r_k[AW-1:0];
        pa_en = 1'b0; pa_city = r_b0;
        pb_en = 1'b0; pb_city = wb_rd;
        case (i_cmd.op)
            S_IDLE: begin
                if (w_fire) begin
                    wa_we    = 1'b1;
                    wa_waddr = r_ld_pos[AW-1:0];
                    wa_wdata = i_parent_a_city;
                    wb_we    = 1'b1;
                    wb_waddr = r_ld_pos[AW-1:0];
                    wb_wdata = i_parent_b_city;
                end
            end
            S_START: begin
                ca_we    = 1'b1;
                ca_waddr = '0;
                ca_wdata = r_b0;
            end
            S_F_RD:  wa_re = !w_i_end;
            S_G_RD:  wb_re = 1'b1;
            S_G_CK: begin
                if (i_cmd.caller == CL_P2) begin
                    pb_en   = 1'b1;
                    pb_city = wb_rd;
                end else if (i_cmd.caller == CL_PE) begin
                    pa_en   = 1'b1;
                    pa_city = wb_rd;
                end
            end
            S_CB_RD: wb_re = !w_i_end;
            S_CB_CK: wb_we = !w_mark;
            S_CA_RD: wa_re = !w_i_end;
            S_CK_RD: begin
                if (o_status.k_end_ca) wa_we = 1'b1;
                else                   ca_re = 1'b1;
            end
            S_D_RD:  wa_re = !w_i_end;
            S_DK_RD: begin
                wb_re    = !w_k_end_rem;
                wb_raddr = r_k[AW-1:0];
            end
            S_Y_RD: begin
                wa_re    = !w_k_end_rem;
                wa_raddr = r_k[AW-1:0];
                wb_re    = !w_k_end_rem;
                wb_raddr = r_k[AW-1:0];
            end
            S_Y_CK: begin
                pa_en   = 1'b1;
                pa_city = wa_rd;
                pb_en   = 1'b1;
                pb_city = wb_rd;
            end
            S_NEW_CYC: begin
                pa_en   = 1'b1;
                pa_city = r_b0;
            end
            S_E_RD: begin
                ca_re = 1'b1;
                cb_re = 1'b1;
            end
            default: ;
        endcase
        // Drop child writes past the city count.
        if (pa_en && ca_room) begin
            ca_we    = 1'b1;
            ca_waddr = r_ca[AW-1:0];
            ca_wdata = pa_city;
        end
        if (pb_en && cb_room) begin
            cb_we    = 1'b1;
            cb_waddr = r_cb[AW-1:0];
            cb_wdata = pb_city;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_pos    <= '0;
            r_ca        <= '0;
            r_cb        <= '0;
            r_rem       <= '0;
            r_cs        <= '0;
            r_second    <= 1'b1;
            r_marks     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                S_IDLE: begin
                    if (w_fire) begin
                        r_ld_pos <= o_status.load_last ? '0 : r_ld_pos + CW'(1);
                    end
                end
                S_START: begin
                    r_ca     <= CW'(1);
                    r_cb     <= '0;
                    r_rem    <= i_city_n;
                    r_cs     <= '0;
                    r_second <= 1'b1;
                    r_marks  <= '0;
                end
                S_G_CK: begin
                    if (i_cmd.caller == CL_P2) begin
                        r_marks[r_i[AW-1:0]] <= 1'b1;
                        if (!o_status.cyc_hit) r_second <= 1'b0;
                    end else if (i_cmd.caller == CL_PE) begin
                        r_second <= 1'b1;
                    end
                end
                S_CB_CK: begin
                    if (w_mark) r_marks[r_i[AW-1:0]] <= 1'b0;
                end
                S_CA_RD: begin
                    if (w_i_end) r_rem <= r_idx;
                end
                S_NEW_CYC: begin
                    r_cs     <= r_ca;
                    r_second <= 1'b1;
                end
                default: ;
            endcase
            if (pa_en && ca_room) r_ca <= r_ca + CW'(1);
            if (pb_en && cb_room) r_cb <= r_cb + CW'(1);
            if (i_cmd.op == S_E_CK && w_out_free) o_out_valid <= 1'b1;
            else if (!i_out_stall)                o_out_valid <= 1'b0;
        end
    end

    // Scan indexes, keys and output payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            S_START: begin
                r_guard  <= GUARD_INIT;
                r_err    <= 1'b0;
                r_last_a <= r_b0;
            end
            S_LOOP: begin
                if (!o_status.loop_done) begin
                    r_guard <= r_guard - GW'(1);
                    r_key   <= r_second ? r_last_a : r_last_b;
                    r_i     <= '0;
                    if (r_second ? o_status.ca_zero : o_status.cb_zero) r_err <= 1'b1;
                end
            end
            S_F_RD: begin
                if (w_i_end) r_err <= 1'b1;
            end
            S_F_CK: begin
                if (!o_status.key_hit) r_i <= r_i + CW'(1);
            end
            S_G_CK: begin
                if (i_cmd.caller == CL_P1) begin
                    r_key <= wb_rd;
                    r_i   <= '0;
                end
            end
            S_C_INIT, S_CA_INIT: begin
                r_i   <= '0;
                r_idx <= '0;
            end
            S_CB_CK: begin
                if (!w_mark) r_idx <= r_idx + CW'(1);
                r_i <= r_i + CW'(1);
            end
            S_CA_CK: begin
                r_v <= wa_rd;
                r_k <= r_cs;
            end
            S_CK_RD: begin
                if (o_status.k_end_ca) begin
                    r_idx <= r_idx + CW'(1);
                    r_i   <= r_i + CW'(1);
                end
            end
            S_CK_CK: begin
                if (o_status.placed_hit) r_i <= r_i + CW'(1);
                else                     r_k <= r_k + CW'(1);
            end
            S_D_INIT: r_i <= '0;
            S_D_CK: begin
                r_v <= wa_rd;
                r_k <= '0;
            end
            S_DK_RD: begin
                if (w_k_end_rem) r_k <= '0;
            end
            S_DK_CK: begin
                if (o_status.found_hit) r_i <= r_i + CW'(1);
                else                    r_k <= r_k + CW'(1);
            end
            S_Y_CK:   r_k <= r_k + CW'(1);
            S_E_INIT: r_k <= '0;
            S_E_CK: begin
                if (w_out_free) begin
                    o_child_a_city <= (r_k < r_ca) ? ca_rd : '0;
                    o_child_b_city <= (r_k < r_cb) ? cb_rd : '0;
                    o_last         <= o_status.emit_last;
                    o_lookup_error <= r_err;
                    r_k            <= r_k + CW'(1);
                end
            end
            default: ;
        endcase
        if (pa_en && ca_room) r_last_a <= pa_city;
        if (pb_en && cb_room) r_last_b <= pb_city;
        // Keep the heads of both working lists at hand.
        if (wa_we && wa_waddr == '0) r_a0 <= wa_wdata;
        if (wb_we && wb_waddr == '0) r_b0 <= wb_wdata;
    end

endmodule

`default_nettype wire

### hw/rtl/permutation_cycle_crossover.sv
// Permutation cycle crossover: two parent tours in, two child tours out.
// Usage: load city_count beats on the input channel, one position of both
// parents per beat, one beat per cycle while o_in_stall is low. After the
// last position the block stalls its input and builds both children by the
// modified cycle crossover. Each lookup scans working list A, reading and
// then comparing one entry at a time, and each cycle closure compacts both
// lists with nested scans. The children then leave as n output beats for n
// cities, each read from the child stores and then registered, the final
// beat with o_last set; o_lookup_error is set on every beat if a lookup in
// list A failed, as with parents that are not matching permutations.
// A stall on the output holds the current beat and the sequencer waits; the
// next tour can start loading as soon as the final beat sits in the output
// register. Reset (synchronous, active low) clears the load position and
// sets city_count to 64; no clearing pass is needed. Write city_count only
// while the block is idle; values outside 2..MAX_CITIES are clamped.
// Depends on pcx_pkg, pcx_ctrl, pcx_dp and pcx_ram.
`default_nettype none

module permutation_cycle_crossover import pcx_pkg::*; #(
    parameter int MAX_CITIES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CITY_W-1:0] i_parent_a_city,
    input  wire logic [CITY_W-1:0] i_parent_b_city,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [CITY_W-1:0] o_child_a_city,
    output logic      [CITY_W-1:0] o_child_b_city,
    output logic                   o_last,
    output logic                   o_lookup_error
);

    localparam int CW = $clog2(MAX_CITIES + 1);

    logic [CFG_W-1:0] r_city_count;
    logic [31:0]      w_cc;
    logic [CW-1:0]    w_city_n;
    t_cmd             w_cmd;
    t_status          w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_city_count <= CITY_COUNT_RST;
        else if (i_cfg_we) r_city_count <= i_cfg_data;
    end

    assign w_cc = {{(32 - CFG_W){1'b0}}, r_city_count};

    always_comb begin
        if (w_cc < 32'd2)                    w_city_n = CW'(2);
        else if (w_cc > 32'(MAX_CITIES))     w_city_n = CW'(MAX_CITIES);
        else                                 w_city_n = CW'(w_cc);
    end

    pcx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    pcx_dp #(.MAX_CITIES(MAX_CITIES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_city_n        (w_city_n),
        .i_in_valid      (i_in_valid),
        .i_parent_a_city (i_parent_a_city),
        .i_parent_b_city (i_parent_b_city),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_child_a_city  (o_child_a_city),
        .o_child_b_city  (o_child_b_city),
        .o_last          (o_last),
        .o_lookup_error  (o_lookup_error)
    );

endmodule

`default_nettype wire

### verif/pcx_checker.sv
// Checker for the permutation cycle crossover block: watches the config port and both
// channels, predicts the child tours for every loaded tour and compares each output beat.
// Depends on pcx_pkg for field widths.
`default_nettype none

module pcx_checker import pcx_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [CITY_W-1:0] i_parent_a_city,
    input  wire logic [CITY_W-1:0] i_parent_b_city,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [CITY_W-1:0] i_child_a_city,
    input  wire logic [CITY_W-1:0] i_child_b_city,
    input  wire logic              i_last,
    input  wire logic              i_lookup_error,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXC = 64;

    typedef struct packed {
        logic [CITY_W-1:0] ca;
        logic [CITY_W-1:0] cb;
        logic              last;
        logic              err;
    } t_child_beat;

    t_child_beat child_q[$];

    logic [CFG_W-1:0]  city_cnt;
    logic [CITY_W-1:0] list_a [MAXC];
    logic [CITY_W-1:0] list_b [MAXC];
    logic [CITY_W-1:0] kid_a  [MAXC];
    logic [CITY_W-1:0] kid_b  [MAXC];
    bit                taken  [MAXC];
    int load_pos, na, nb, rem, cyc_start;
    bit second;

    assign o_pending = child_q.size();

    function automatic int tour_len();
        int n;
        n = city_cnt;
        if (n < 2) n = 2;
        if (n > MAXC) n = MAXC;
        return n;
    endfunction

    function automatic int pos_in_a(logic [CITY_W-1:0] c);
        for (int i = 0; i < rem && i < MAXC; i++)
            if (list_a[i] == c) return i;
        return -1;
    endfunction

    function automatic void place_a(int n, logic [CITY_W-1:0] c);
        if (na < n) begin
            kid_a[na] = c;
            na++;
        end
    endfunction

    function automatic void place_b(int n, logic [CITY_W-1:0] c);
        if (nb < n) begin
            kid_b[nb] = c;
            nb++;
        end
    endfunction

    // Compact both lists; return 1 when the leftovers get copied straight across.
    function automatic bit close_cycle(int n);
        int idx;
        bit hit;
        idx = 0;
        for (int i = 0; i < rem; i++) begin
            if (!taken[i]) begin
                list_b[idx] = list_b[i];
                idx++;
            end else begin
                taken[i] = 0;
            end
        end
        idx = 0;
        for (int i = 0; i < rem; i++) begin
            hit = 0;
            for (int k = cyc_start; k < na; k++)
                if (list_a[i] == kid_a[k]) begin
                    hit = 1;
                    break;
                end
            if (!hit) begin
                list_a[idx] = list_a[i];
                idx++;
            end
        end
        rem = idx;
        for (int i = 0; i < rem; i++) begin
            hit = 0;
            for (int k = 0; k < rem; k++)
                if (list_a[i] == list_b[k]) begin
                    hit = 1;
                    break;
                end
            if (!hit) begin
                for (int k = 0; k < rem; k++) begin
                    place_a(n, list_a[k]);
                    place_b(n, list_b[k]);
                end
                return 1;
            end
        end
        cyc_start = na;
        place_a(n, list_b[0]);
        second = 1;
        return 0;
    endfunction

    // Build both children; return 1 on a failed lookup.
    function automatic bit build_children(int n);
        int guard, p1, p2;
        logic [CITY_W-1:0] c;
        guard = 4 * MAXC + 8;
        for (int i = 0; i < MAXC; i++) begin
            kid_a[i] = '0;
            kid_b[i] = '0;
            taken[i] = 0;
        end
        na = 0;
        nb = 0;
        rem = n;
        cyc_start = 0;
        second = 1;
        place_a(n, list_b[0]);
        while ((na < n || nb < n) && guard > 0) begin
            guard--;
            if (second) begin
                if (na == 0) return 1;
                p1 = pos_in_a(kid_a[na-1]);
                if (p1 < 0) return 1;
                p2 = pos_in_a(list_b[p1]);
                if (p2 < 0) return 1;
                c = list_b[p2];
                place_b(n, c);
                taken[p2] = 1;
                if (list_a[0] == c) begin
                    if (close_cycle(n)) return 0;
                    continue;
                end
                second = 0;
            end else begin
                if (nb == 0) return 1;
                p1 = pos_in_a(kid_b[nb-1]);
                if (p1 < 0) return 1;
                place_a(n, list_b[p1]);
                second = 1;
            end
        end
        return 0;
    endfunction

    function automatic void load_position_beat(logic [CITY_W-1:0] a, logic [CITY_W-1:0] b);
        int n;
        bit err;
        t_child_beat e;
        n = tour_len();
        if (load_pos < MAXC) begin
            list_a[load_pos] = a;
            list_b[load_pos] = b;
        end
        load_pos++;
        if (load_pos < n) return;
        load_pos = 0;
        err = build_children(n);
        for (int k = 0; k < n; k++) begin
            e.ca = kid_a[k];
            e.cb = kid_b[k];
            e.last = (k + 1 == n);
            e.err = err;
            child_q.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        t_child_beat e, got;
        if (!i_rst_n) begin
            city_cnt <= CITY_COUNT_RST;
            load_pos = 0;
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                load_position_beat(i_parent_a_city, i_parent_b_city);
            if (i_out_valid && !i_out_stall) begin
                got = '{i_child_a_city, i_child_b_city, i_last, i_lookup_error};
                if (child_q.size() == 0) begin
                    $display("%0t: unexpected child beat %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = child_q.pop_front();
                    if (e != got) begin
                        $display("%0t: child beat mismatch exp a=%0d b=%0d last=%0d err=%0d",
                                 $time, e.ca, e.cb, e.last, e.err);
                        $display("%0t:                      got a=%0d b=%0d last=%0d err=%0d",
                                 $time, got.ca, got.cb, got.last, got.err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // Config takes effect for the beats after this edge.
            if (i_cfg_we) city_cnt <= i_cfg_data;
        end
    end
endmodule

`default_nettype wire

### verif/permutation_cycle_crossover_tb.sv
// Testbench top for permutation_cycle_crossover: drives parent tours and city counts,
// paces both channels, and gives the verdict. Depends on pcx_pkg, pcx_checker and the RTL.
`default_nettype none

module permutation_cycle_crossover_tb;
    import pcx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES = 3000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              cfg_we = 0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [CITY_W-1:0] pa_city = '0;
    logic [CITY_W-1:0] pb_city = '0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [CITY_W-1:0] ca_city, cb_city;
    logic              last, lookup_error;
    int fail_count, pending;
    int tx_idle_pct = 0, rx_idle_pct = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0;
    int cycles = 0;
    int beats_sent = 0;

    always #5 i_clk = ~i_clk;

    permutation_cycle_crossover u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_parent_a_city(pa_city), .i_parent_b_city(pb_city),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_child_a_city(ca_city), .o_child_b_city(cb_city),
        .o_last(last), .o_lookup_error(lookup_error)
    );

    pcx_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_parent_a_city(pa_city), .i_parent_b_city(pb_city),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_child_a_city(ca_city), .i_child_b_city(cb_city),
        .i_last(last), .i_lookup_error(lookup_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver pacing; a long hold-off is counted here once requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic write_city_count(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_beat(logic [CITY_W-1:0] a, logic [CITY_W-1:0] b);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        pa_city <= a;
        pb_city <= b;
        do @(posedge i_clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic shuffle(ref logic [CITY_W-1:0] t[64], input int n);
        int j;
        logic [CITY_W-1:0] x;
        for (int i = 0; i < n; i++) t[i] = CITY_W'(i);
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            x = t[i];
            t[i] = t[j];
            t[j] = x;
        end
    endtask

    // kind: 0 matching permutations, 1 random cities, 2 duplicated city, 3 same tour twice
    task automatic send_tour(int n, int kind);
        logic [CITY_W-1:0] ta[64], tb[64];
        shuffle(ta, n);
        shuffle(tb, n);
        if (kind == 1) begin
            for (int i = 0; i < n; i++) begin
                ta[i] = CITY_W'($urandom());
                tb[i] = CITY_W'($urandom());
            end
        end else if (kind == 2) begin
            tb[$urandom_range(0, n - 1)] = tb[$urandom_range(0, n - 1)] ^ 6'd1;
        end else if (kind == 3) begin
            tb = ta;
        end
        for (int i = 0; i < n; i++) send_beat(ta[i], tb[i]);
    endtask

    task automatic idle_line();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    initial begin
        int n, kind, goal, pick;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of the count, clamping, mid-load count change, bad parents.
        tx_idle_pct = 38;
        rx_idle_pct = 66;
        write_city_count(7'd2);
        send_tour(2, 3);
        send_tour(2, 0);
        send_beat(6'd0, 6'd0);
        send_beat(6'd63, 6'd63);
        idle_line();
        drain();
        write_city_count(7'd0);
        send_tour(2, 0);
        idle_line();
        drain();
        write_city_count(7'd1);
        send_tour(2, 1);
        idle_line();
        drain();
        write_city_count(7'd10);
        send_beat(6'd0, 6'd1);
        idle_line();
        drain();
        write_city_count(7'd3);
        send_beat(6'd1, 6'd2);
        send_beat(6'd2, 6'd0);
        idle_line();
        drain();
        write_city_count(7'd127);
        send_tour(64, 0);
        idle_line();
        drain();

        // Random: three pacing phases, several counts each.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
            rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;
            goal = beats_sent + 70;
            while (beats_sent < goal) begin
                pick = $urandom_range(0, 9);
                n = (pick == 0) ? $urandom_range(9, 20) : $urandom_range(2, 8);
                write_city_count(CFG_W'(n));
                if (phase == 2 && hold_req == 0) hold_req = 1;
                repeat ($urandom_range(3, 6)) begin
                    kind = $urandom_range(0, 99);
                    kind = (kind < 80) ? 0 : (kind < 88) ? 1 : (kind < 95) ? 2 : 3;
                    send_tour(n, kind);
                end
                idle_line();
                drain();
            end
        end
        write_city_count(7'd64);
        send_tour(64, 1);
        idle_line();
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire

### permutation_cycle_crossover.f
hw/rtl/pcx_pkg.sv
hw/rtl/pcx_ram.sv
hw/rtl/pcx_ctrl.sv
hw/rtl/pcx_dp.sv
hw/rtl/permutation_cycle_crossover.sv
verif/pcx_checker.sv
verif/permutation_cycle_crossover_tb.sv
